### rtl/bgl_pkg.sv
// ----------------------------------------------------------------------------
// bgl_pkg: shared types and constants for the bitmap glyph layout block
// Stream layouts, register indexes, queue entry, control struct, divide step.
// ----------------------------------------------------------------------------
package bgl_pkg;

	localparam int MAX_GLYPHS_DEF = 256;
	localparam int POS_FRAC_DEF   = 8;
	localparam int QUEUE_DEPTH    = 2;

	// stream widths: 117 payload bits in, 202 out, padded to whole bytes
	localparam int S_DATA_W = 120;
	localparam int M_DATA_W = 208;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_SPACE   = 8'd32;

	// register indexes on the configuration channel
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPHS_ROW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_WTAB    = 3'd5;
	localparam int CFG_DATA_W = 9;

	// register reset values
	localparam logic [7:0] RST_CELL_WIDTH  = 8'd8;
	localparam logic [7:0] RST_CELL_HEIGHT = 8'd8;
	localparam logic [8:0] RST_GLYPHS_ROW  = 9'd16;
	localparam logic [6:0] RST_FIRST_CODE  = 7'd32;
	localparam logic [8:0] RST_GLYPH_COUNT = 9'd96;

	localparam int ATLAS_ONE = 65536;
	localparam int STEP_W    = 17;
	localparam logic [STEP_W-1:0] RST_STEP = STEP_W'(ATLAS_ONE / 16);

	localparam logic [11:0] SCALE_ONE = 12'd256;
	localparam logic [23:0] POS_MAX   = 24'h7FFFFF;
	localparam logic [19:0] SIZE_MAX  = 20'hFFFFF;
	localparam logic [23:0] V_MAX     = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_NEWLINE,
		OP_ADVANCE,
		OP_GLYPH
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SIZE,
		BK_DIV,
		BK_MUL,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		op_t         op;
		logic        start;
		logic [23:0] origin_x;
		logic [23:0] origin_y;
		logic [11:0] scale;
		logic [31:0] color;
		logic [7:0]  idx;
		logic [7:0]  wval;
	} entry_t;

	// configuration the back end needs
	typedef struct packed {
		logic [7:0]        cell_width;
		logic [7:0]        cell_height;
		logic [8:0]        gpr_eff;
		logic              use_wtab;
		logic [STEP_W-1:0] step;
	} cfg_t;

	// one restoring divide step, divisor up to 511: returns {rem, quotient bit}
	function automatic logic [9:0] div_step(logic [8:0] rem, logic din, logic [8:0] d);
		logic [9:0] t;
		t = {rem, din};
		if (t >= {1'b0, d}) begin
			return {9'(t - {1'b0, d}), 1'b1};
		end else begin
			return {t[8:0], 1'b0};
		end
	endfunction

endpackage

### rtl/bgl_front.sv
// ----------------------------------------------------------------------------
// bgl_front: input acceptance, classification and configuration registers
// Sorts each character into an operation and computes the atlas step.
// ----------------------------------------------------------------------------
module bgl_front #(
	parameter int MAX_GLYPHS = bgl_pkg::MAX_GLYPHS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bgl_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                            s_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bgl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bgl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            q_push,
	output bgl_pkg::entry_t                 q_entry,
	input  logic                            q_full,
	output bgl_pkg::cfg_t                   cfg
);
	import bgl_pkg::*;

	logic [7:0]        cell_width_q, cell_height_q;
	logic [8:0]        gpr_q, glyph_count_q;
	logic [6:0]        first_code_q;
	logic              use_wtab_q;
	logic [8:0]        gpr_eff;

	logic              step_busy_q;
	logic [4:0]        step_cnt_q;
	logic [8:0]        step_rem_q;
	logic [STEP_W-1:0] step_quo_q, step_q;
	logic [9:0]        step_r;

	logic              mode, start;
	logic [7:0]        code, width_index;
	logic [6:0]        diff;
	logic              in_font, wi_ok, accept;
	op_t               op;

	assign cfg_ready = 1'b1;
	assign gpr_eff   = (gpr_q == 9'd0) ? 9'd1 : gpr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= RST_CELL_WIDTH;
			cell_height_q <= RST_CELL_HEIGHT;
			gpr_q         <= RST_GLYPHS_ROW;
			first_code_q  <= RST_FIRST_CODE;
			glyph_count_q <= RST_GLYPH_COUNT;
			use_wtab_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data[7:0];
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data[7:0];
				CFG_GLYPHS_ROW:  gpr_q         <= cfg_data;
				CFG_FIRST_CODE:  first_code_q  <= cfg_data[6:0];
				CFG_GLYPH_COUNT: glyph_count_q <= cfg_data;
				CFG_USE_WTAB:    use_wtab_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// 65536 / glyphs_per_row, one quotient bit per cycle, MSB first
	assign step_r = div_step(step_rem_q, step_cnt_q == 5'd0, gpr_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_busy_q <= 1'b0;
			step_cnt_q  <= '0;
			step_rem_q  <= '0;
			step_quo_q  <= '0;
			step_q      <= RST_STEP;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_GLYPHS_ROW) begin
			step_busy_q <= 1'b1;
			step_cnt_q  <= '0;
			step_rem_q  <= '0;
			step_quo_q  <= '0;
		end else if (step_busy_q) begin
			step_rem_q <= step_r[9:1];
			step_quo_q <= {step_quo_q[STEP_W-2:0], step_r[0]};
			step_cnt_q <= step_cnt_q + 5'd1;
			if (step_cnt_q == 5'(STEP_W - 1)) begin
				step_busy_q <= 1'b0;
				step_q      <= {step_quo_q[STEP_W-2:0], step_r[0]};
			end
		end
	end

	// unpack: start_text, char_code, origin_x, origin_y, scale, color,
	// width_index, width_value from the low bits up
	assign mode        = s_tuser;
	assign start       = s_tdata[0];
	assign code        = s_tdata[8:1];
	assign width_index = s_tdata[108:101];
	assign diff        = code[6:0] - first_code_q;

	assign in_font = !code[7] && (code[6:0] >= first_code_q)
		&& ({2'b00, diff} < glyph_count_q) && (32'(diff) < MAX_GLYPHS);
	assign wi_ok   = 32'(width_index) < MAX_GLYPHS;

	always_comb begin
		if (mode) begin
			op = OP_WRITE;
		end else if (code == CODE_NEWLINE) begin
			op = OP_NEWLINE;
		end else if (code == CODE_SPACE || !in_font) begin
			op = OP_ADVANCE;
		end else begin
			op = OP_GLYPH;
		end
	end

	assign s_tready = !q_full && !step_busy_q;
	assign accept   = s_tvalid && s_tready;
	// out-of-range table writes are taken and dropped
	assign q_push   = accept && !(mode && !wi_ok);

	always_comb begin
		q_entry.op       = op;
		q_entry.start    = start;
		q_entry.origin_x = s_tdata[32:9];
		q_entry.origin_y = s_tdata[56:33];
		q_entry.scale    = s_tdata[68:57];
		q_entry.color    = s_tdata[100:69];
		q_entry.idx      = mode ? width_index : {1'b0, diff};
		q_entry.wval     = s_tdata[116:109];
	end

	assign cfg.cell_width  = cell_width_q;
	assign cfg.cell_height = cell_height_q;
	assign cfg.gpr_eff     = gpr_eff;
	assign cfg.use_wtab    = use_wtab_q;
	assign cfg.step        = step_q;

endmodule

### rtl/bgl_fifo.sv
// ----------------------------------------------------------------------------
// bgl_fifo: short queue of classified operations between front and back
// Register-based FIFO, head entry shown combinationally.
// ----------------------------------------------------------------------------
module bgl_fifo #(
	parameter int DEPTH = bgl_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bgl_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output bgl_pkg::entry_t head,
	output logic            empty
);
	import bgl_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

### rtl/bgl_back.sv
// ----------------------------------------------------------------------------
// bgl_back: cursor state, width table, atlas divide and result register
// Sequencer runs one operation at a time from the queue head.
// ----------------------------------------------------------------------------
module bgl_back #(
	parameter int MAX_GLYPHS    = bgl_pkg::MAX_GLYPHS_DEF,
	parameter int POS_FRAC_BITS = bgl_pkg::POS_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bgl_pkg::cfg_t                cfg,
	input  logic                         q_empty,
	input  bgl_pkg::entry_t              q_head,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bgl_pkg::M_DATA_W-1:0] m_tdata
);
	import bgl_pkg::*;

	localparam int IW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

	bk_state_t state_q, state_d;
	op_t       op_q;

	logic [23:0] line_x_q, cur_x_q, cur_y_q;
	logic [11:0] scale_q;
	logic [31:0] color_q;

	logic [7:0]  wtab [MAX_GLYPHS];
	logic [7:0]  rd_q;

	logic [19:0] pcw_q, pch_q, pw_q;
	logic [8:0]  rem_q;
	logic [7:0]  quo_q;
	logic [1:0]  dcnt_q;
	logic [16:0] u0_q;
	logic [23:0] v0_q;

	logic [9:0]  r1, r2;
	logic [19:0] cw, ch, w;
	logic [16:0] u1;
	logic [24:0] v1_sum;
	logic [23:0] v1;
	logic        div_en, fin_ok, out_load;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	function automatic logic [19:0] sat_size(logic [19:0] q8);
		logic [31:0] t;
		t = (32'(q8) << POS_FRAC_BITS) >> 8;
		return (t > 32'(SIZE_MAX)) ? SIZE_MAX : t[19:0];
	endfunction

	function automatic logic [23:0] sat_add(logic [23:0] a, logic [19:0] b);
		logic signed [25:0] s;
		s = $signed({{2{a[23]}}, a}) + $signed({6'b0, b});
		return (s > $signed({2'b00, POS_MAX})) ? POS_MAX : s[23:0];
	endfunction

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!q_empty) state_d = (q_head.op == OP_WRITE) ? BK_IDLE : BK_SIZE;
			BK_SIZE: state_d = (op_q == OP_GLYPH) ? BK_DIV : BK_FIN;
			BK_DIV:  if (dcnt_q == 2'd3) state_d = BK_MUL;
			BK_MUL:  state_d = BK_FIN;
			BK_FIN:  if (fin_ok) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == BK_IDLE) && !q_empty;
		div_en   = (state_q == BK_SIZE) || (state_q == BK_DIV);
		fin_ok   = (state_q == BK_FIN) && (op_q != OP_GLYPH || !m_tvalid_q || m_tready);
		out_load = fin_ok && (op_q == OP_GLYPH);
	end

	// two quotient bits per cycle: row in quo_q, column in rem_q
	assign r1 = div_step(rem_q, quo_q[7], cfg.gpr_eff);
	assign r2 = div_step(r1[9:1], quo_q[6], cfg.gpr_eff);

	assign cw     = sat_size(pcw_q);
	assign ch     = sat_size(pch_q);
	assign w      = cfg.use_wtab ? sat_size(pw_q) : cw;
	assign u1     = 17'({1'b0, u0_q} + {1'b0, cfg.step});
	assign v1_sum = {1'b0, v0_q} + 25'(cfg.step);
	assign v1     = (v1_sum > {1'b0, V_MAX}) ? V_MAX : v1_sum[23:0];

	// width table, no reset
	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == OP_WRITE) begin
			wtab[q_head.idx[IW-1:0]] <= q_head.wval;
		end
		rd_q <= wtab[q_head.idx[IW-1:0]];
	end

	// datapath without reset
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= q_head.op;
			rem_q  <= '0;
			quo_q  <= q_head.idx;
			dcnt_q <= '0;
		end
		if (state_q == BK_SIZE) begin
			pcw_q <= 20'(cfg.cell_width) * 20'(scale_q);
			pch_q <= 20'(cfg.cell_height) * 20'(scale_q);
			pw_q  <= 20'(rd_q) * 20'(scale_q);
		end
		if (div_en) begin
			rem_q  <= r2[9:1];
			quo_q  <= {quo_q[5:0], r1[0], r2[0]};
			dcnt_q <= dcnt_q + 2'd1;
		end
		if (state_q == BK_MUL) begin
			u0_q <= 17'(25'(rem_q[7:0]) * 25'(cfg.step));
			v0_q <= 24'(25'(quo_q) * 25'(cfg.step));
		end
		if (out_load) begin
			m_tdata_q <= {6'b0, color_q, v1, v0_q, u1, u0_q, ch, w, cur_y_q, cur_x_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			line_x_q   <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			scale_q    <= SCALE_ONE;
			color_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_head.op != OP_WRITE && q_head.start) begin
				line_x_q <= q_head.origin_x;
				cur_x_q  <= q_head.origin_x;
				cur_y_q  <= q_head.origin_y;
				scale_q  <= q_head.scale;
				color_q  <= q_head.color;
			end
			if (fin_ok) begin
				case (op_q)
					OP_NEWLINE: begin
						cur_x_q <= line_x_q;
						cur_y_q <= sat_add(cur_y_q, ch);
					end
					OP_ADVANCE: cur_x_q <= sat_add(cur_x_q, cw);
					OP_GLYPH:   cur_x_q <= sat_add(cur_x_q, w);
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_col_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL) |-> (rem_q < cfg.gpr_eff))
		else $error("column not below glyphs per row");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL) |-> ($past(state_q) == BK_DIV && $past(dcnt_q) == 2'd3))
		else $error("atlas divide cut short");

	a_result_from_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == BK_FIN && op_q == OP_GLYPH))
		else $error("result raised outside glyph finish");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FIN && op_q == OP_GLYPH && m_tvalid_q && !m_tready)
		|=> (state_q == BK_FIN))
		else $error("glyph finished over a stalled result");

endmodule

### rtl/bitmap_glyph_layout.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_layout: text stream to glyph rectangle layout
// Front end classifies characters, back end walks the cursor and emits quads.
// ----------------------------------------------------------------------------
// Usage:
//  s_* carries one character or one width table write per transaction;
//  s_tuser is mode (1 = table write). m_* carries one glyph rectangle per
//  transaction. cfg_* writes registers 0..5 (cell width, cell height, glyphs
//  per row, first code, glyph count, width table enable); the user must do
//  so only while idle, which the block itself does not enforce. Each glyph
//  is queued, then the back end sequencer runs it through a pop step, a
//  table/size step that takes the first of four 2-bit row/column divide
//  steps, the remaining divide steps, a multiply step and a finish step that
//  registers its rectangle onto m_*; newline, space and out-of-font codes
//  take the pop, size and finish steps, table writes only the pop step; the
//  2-entry queue lets s_* keep accepting meanwhile. A write of glyphs per row
//  starts a divide for the atlas step; s_tready stays low during it.
//  Reset: cursor, origin and colour clear, scale is 1.0, registers take their
//  defaults; the width table holds garbage until written. No clearing pass.
//  Stall: a glyph whose result cannot be loaded waits in the finish step with
//  the cursor unchanged; the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module bitmap_glyph_layout #(
	parameter int MAX_GLYPHS    = bgl_pkg::MAX_GLYPHS_DEF,
	parameter int POS_FRAC_BITS = bgl_pkg::POS_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// start_text[0], char_code[8:1], origin_x[32:9], origin_y[56:33],
	// scale[68:57], color[100:69], width_index[108:101], width_value[116:109]
	input  logic [bgl_pkg::S_DATA_W-1:0]   s_tdata,
	// mode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// sprite_x[23:0], sprite_y[47:24], sprite_width[67:48],
	// sprite_height[87:68], tex_u0[104:88], tex_u1[121:105],
	// tex_v0[145:122], tex_v1[169:146], glyph_color[201:170]
	output logic [bgl_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bgl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bgl_pkg::*;

	// front to queue
	logic   q_push, q_full;
	entry_t q_entry;
	// queue to back
	logic   q_pop, q_empty;
	entry_t q_head;
	// registers and atlas step seen by the back end
	cfg_t   cfg;

	bgl_front #(
		.MAX_GLYPHS(MAX_GLYPHS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_push   (q_push),
		.q_entry  (q_entry),
		.q_full   (q_full),
		.cfg      (cfg)
	);

	bgl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(q_entry),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	bgl_back #(
		.MAX_GLYPHS   (MAX_GLYPHS),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
